### src/avsq_pkg.sv
// shared types and constants for the envelope and square voice
`timescale 1ns / 1ps

package avsq_pkg;

   localparam logic [15:0] TICK_UNIT   = 16'd52150;
   localparam logic [15:0] FULL16      = 16'hFFFF;
   localparam logic [7:0]  FRAC_WRAP   = 8'd100;

   // register indexes on the configuration port
   localparam logic [2:0] REG_ATTACK_TIME   = 3'd0;
   localparam logic [2:0] REG_DECAY_TIME    = 3'd1;
   localparam logic [2:0] REG_RELEASE_TIME  = 3'd2;
   localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd3;
   localparam logic [2:0] REG_PEAK_LEVEL    = 3'd4;
   localparam logic [2:0] REG_PERIOD_TICKS  = 3'd5;
   localparam logic [2:0] REG_PERIOD_HUND   = 3'd6;

   typedef enum logic [1:0] {
      STG_ATTACK  = 2'd0,
      STG_DECAY   = 2'd1,
      STG_SUSTAIN = 2'd2,
      STG_RELEASE = 2'd3
   } env_stage_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_STEP,
      S_DIV,
      S_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0]  attack_time;
      logic [7:0]  decay_time;
      logic [7:0]  release_time;
      logic [15:0] sustain_level;
      logic [15:0] peak_level;
      logic [15:0] period_ticks;
      logic [6:0]  period_hundredths;
   } csr_type;

   typedef struct packed {
      logic take;      // capture the accepted item
      logic step;      // apply one tick to the voice state
      logic out_load;  // move the voice state into the result register
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

### src/adsr_square_voice.sv
// top level of the envelope and square voice: register file, controller and datapath
`timescale 1ns / 1ps

// Each input item is one timer tick and yields exactly one result item. Every
// second tick (starting with the second after reset) steps the attack, decay,
// sustain, release envelope and the square oscillator while the note is on or
// the envelope is in release; a skipped tick returns the held sample. After an
// item is accepted the controller steps the voice, waits while the divider is
// busy and then loads the result register. On a tick where the envelope
// changes stage from attack to decay or from decay to sustain with a nonzero
// divisor, the step interval comes from a serial divider that produces one
// quotient bit per clock; the result is loaded once the divider has finished.
// A new item is accepted as soon as the previous one has been loaded into the
// result register, even if that result has not been taken yet; a result still
// waiting when the next one is ready holds the controller until it is taken.
// Registers are written through the APB-style port at byte address 4 * index
// and should be changed only while no tick is in flight.
module adsr_square_voice
   import avsq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // tick items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] note_on, [1] start_release, rest zero
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] dac_value, [17:16] env_stage,
                                    // [33:18] env_level, rest zero
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   csr_type    csr_ff, csr_in;
   logic       csr_wr;
   logic [2:0] csr_idx;
   cmd_type    cmd;
   status_type status;
   logic [15:0] dac_value;
   logic [1:0]  env_stage;
   logic [15:0] env_level;

   // register file, write at the access phase, no wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[4:2];

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_ATTACK_TIME:   csr_in.attack_time       = csr_pwdata[7:0];
            REG_DECAY_TIME:    csr_in.decay_time        = csr_pwdata[7:0];
            REG_RELEASE_TIME:  csr_in.release_time      = csr_pwdata[7:0];
            REG_SUSTAIN_LEVEL: csr_in.sustain_level     = csr_pwdata[15:0];
            REG_PEAK_LEVEL:    csr_in.peak_level        = csr_pwdata[15:0];
            REG_PERIOD_TICKS:  csr_in.period_ticks      = csr_pwdata[15:0];
            REG_PERIOD_HUND:   csr_in.period_hundredths = csr_pwdata[6:0];
            default:           csr_in = csr_ff;   // unused address, ignored
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ATTACK_TIME:   csr_prdata = {24'd0, csr_ff.attack_time};
         REG_DECAY_TIME:    csr_prdata = {24'd0, csr_ff.decay_time};
         REG_RELEASE_TIME:  csr_prdata = {24'd0, csr_ff.release_time};
         REG_SUSTAIN_LEVEL: csr_prdata = {16'd0, csr_ff.sustain_level};
         REG_PEAK_LEVEL:    csr_prdata = {16'd0, csr_ff.peak_level};
         REG_PERIOD_TICKS:  csr_prdata = {16'd0, csr_ff.period_ticks};
         REG_PERIOD_HUND:   csr_prdata = {25'd0, csr_ff.period_hundredths};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.attack_time       <= 8'd1;
         csr_ff.decay_time        <= 8'd1;
         csr_ff.release_time      <= 8'd1;
         csr_ff.sustain_level     <= 16'h2000;
         csr_ff.peak_level        <= 16'h3FFF;
         csr_ff.period_ticks      <= 16'd1;
         csr_ff.period_hundredths <= 7'd0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // sequencing: accept, step the voice, wait for the divider, load result
   avsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   avsq_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr           (csr_ff),
      .note_on       (req_tdata[0]),
      .start_release (req_tdata[1]),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .dac_value     (dac_value),
      .env_stage     (env_stage),
      .env_level     (env_level)
   );

   assign rsp_tdata = {6'd0, env_level, env_stage, dac_value};

   // the sample is never zero
   a_dac_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15:0] != 16'd0))
      else $error("zero sample in result item");

   // no new item while the divider is still working on the previous one
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_tready)
      else $error("item accepted during division");

   // one item at a time: acceptance closes the input side for the next cycle
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready && !cmd.out_load))
      else $error("input side still open after an accept");

   // a sustain level write lands in the register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_idx == REG_SUSTAIN_LEVEL) |=>
         (csr_ff.sustain_level == $past(csr_pwdata[15:0])))
      else $error("sustain level write lost");

endmodule

### src/avsq_div.sv
// serial divider: fixed tick unit over a 16-bit divisor, one quotient bit a cycle
`timescale 1ns / 1ps

module avsq_div
   import avsq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] den,
   output logic        busy,
   output logic        done,
   output logic [15:0] quotient
);

   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] den_ff, den_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [16:0] trial;
   logic        qbit;
   logic [15:0] quo_step;

   // shift one dividend bit into the partial remainder and try a subtract
   always_comb begin
      trial    = {rem_ff, quo_ff[15]};
      qbit     = (trial >= {1'b0, den_ff});
      quo_step = {quo_ff[14:0], qbit};
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd0;
         den_in  = den;
         rem_in  = 16'd0;
         quo_in  = TICK_UNIT;
      end else if (busy_ff) begin
         rem_in = qbit ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
         quo_in = quo_step;
         cnt_in = 4'(cnt_ff + 4'd1);
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = busy_ff && (cnt_ff == 4'd15);
   assign quotient = quo_step;

endmodule

### src/avsq_dp.sv
// voice datapath: envelope stage machine state, period counter, sample and result register
`timescale 1ns / 1ps

module avsq_dp
   import avsq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  csr_type     csr,
   input  logic        note_on,
   input  logic        start_release,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [15:0] dac_value,
   output logic [1:0]  env_stage,
   output logic [15:0] env_level
);

   logic          note_ff, rel_ff;
   logic          skip_ff, skip_in;
   env_stage_type stage_ff, stage_in;
   logic [7:0]    sub_ff, sub_in;
   logic [15:0]   time_ff, time_in;
   logic [15:0]   level_ff, level_in;
   logic [15:0]   step_ff, step_in;
   logic [15:0]   period_ff, period_in;
   logic [7:0]    frac_ff, frac_in;
   logic          phase_ff, phase_in;
   logic [15:0]   sample_ff, sample_in;
   logic          valid_ff, valid_in;
   logic [15:0]   dac_ff;
   logic [1:0]    stg_ff;
   logic [15:0]   lvl_ff;

   env_stage_type stage_eff;
   logic          active;
   logic          low_time;
   logic          it_attack, it_decay, it_release, it_ramp;
   logic          need_div;
   logic [15:0]   div_den;
   logic          div_start, div_busy, div_done;
   logic [15:0]   div_q;
   logic [7:0]    frac_base;
   logic [15:0]   sample_raw;

   avsq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .den      (div_den),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // time / tick unit is 0 or 1 for a 16-bit count
   always_comb begin
      low_time   = (time_ff < TICK_UNIT);
      it_attack  = low_time ? (csr.attack_time  != 8'd0) : (csr.attack_time  > 8'd1);
      it_decay   = low_time ? (csr.decay_time   != 8'd0) : (csr.decay_time   > 8'd1);
      it_release = low_time ? (csr.release_time != 8'd0) : (csr.release_time > 8'd1);
   end

   always_comb begin
      stage_eff = rel_ff ? STG_RELEASE : stage_ff;
      active    = !skip_ff && (note_ff || (stage_eff == STG_RELEASE));
      it_ramp   = (stage_eff == STG_DECAY) ? it_decay : it_release;

      skip_in   = skip_ff;
      stage_in  = stage_ff;
      sub_in    = sub_ff;
      time_in   = time_ff;
      level_in  = level_ff;
      step_in   = step_ff;
      period_in = period_ff;
      frac_in   = frac_ff;
      phase_in  = phase_ff;
      sample_in = sample_ff;
      need_div  = 1'b0;
      div_den   = csr.sustain_level;
      frac_base = frac_ff;
      sample_raw = 16'd0;

      if (cmd.step) begin
         stage_in = stage_eff;
         skip_in  = !skip_ff;
         if (active) begin
            // envelope
            unique case (stage_eff)
               STG_ATTACK: begin
                  if (sub_ff == 8'd0 && it_attack) begin
                     sub_in  = 8'd1;
                     time_in = 16'(time_ff + 16'd1);
                  end else if (level_ff < csr.peak_level && it_attack) begin
                     sub_in   = 8'd0;
                     time_in  = 16'(time_ff + 16'd1);
                     level_in = 16'(level_ff + 16'd1);
                  end else begin
                     sub_in   = 8'd0;
                     time_in  = 16'd0;
                     level_in = csr.peak_level;
                     need_div = 1'b1;
                     div_den  = csr.sustain_level;
                     stage_in = STG_DECAY;
                  end
               end
               STG_SUSTAIN: begin
                  sub_in = 8'(sub_ff + 8'd1);
               end
               STG_DECAY, STG_RELEASE: begin
                  if ({8'd0, sub_ff} < step_ff && it_ramp) begin
                     sub_in  = 8'(sub_ff + 8'd1);
                     time_in = 16'(time_ff + 16'd1);
                  end else if (it_ramp && level_ff != 16'd0) begin
                     sub_in   = 8'd0;
                     time_in  = 16'(time_ff + 16'd1);
                     level_in = 16'(level_ff - 16'd1);
                  end else begin
                     sub_in  = 8'd0;
                     time_in = 16'd0;
                     if (stage_eff == STG_DECAY) begin
                        level_in = csr.sustain_level;
                        need_div = 1'b1;
                        div_den  = 16'(csr.peak_level - csr.sustain_level);
                        stage_in = STG_SUSTAIN;
                     end else begin
                        level_in = 16'd0;
                        step_in  = 16'd0;
                        stage_in = STG_ATTACK;
                     end
                  end
               end
               default: begin
                  sub_in = sub_ff;
               end
            endcase
            if (need_div && div_den == 16'd0) begin
               step_in = FULL16;
            end

            // period counter with hundredths stretch
            if (period_ff != 16'd0) begin
               period_in = 16'(period_ff - 16'd1);
            end else begin
               if (frac_ff < FRAC_WRAP) begin
                  period_in = 16'(csr.period_ticks - 16'd1);
               end else begin
                  frac_base = 8'(frac_ff - FRAC_WRAP);
                  period_in = csr.period_ticks;
               end
               frac_in = 8'(frac_base + {1'b0, csr.period_hundredths});
            end
            if (period_in == 16'd1) begin
               phase_in = !phase_ff;
            end
            sample_raw = phase_in ? level_in : ~level_in;
            sample_in  = (sample_raw == 16'd0) ? 16'd1 : sample_raw;
         end else if (!skip_ff) begin
            period_in = 16'd0;
            frac_in   = 8'd0;
            sample_in = 16'd1;
         end
      end
      if (div_done) begin
         step_in = div_q;
      end
   end

   assign div_start = cmd.step && active && need_div && (div_den != 16'd0);

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff   <= 1'b1;
         stage_ff  <= STG_ATTACK;
         sub_ff    <= 8'd0;
         time_ff   <= 16'd0;
         level_ff  <= 16'd0;
         step_ff   <= 16'd0;
         period_ff <= 16'd0;
         frac_ff   <= 8'd0;
         phase_ff  <= 1'b1;
         sample_ff <= 16'd1;
         valid_ff  <= 1'b0;
      end else begin
         skip_ff   <= skip_in;
         stage_ff  <= stage_in;
         sub_ff    <= sub_in;
         time_ff   <= time_in;
         level_ff  <= level_in;
         step_ff   <= step_in;
         period_ff <= period_in;
         frac_ff   <= frac_in;
         phase_ff  <= phase_in;
         sample_ff <= sample_in;
         valid_ff  <= valid_in;
      end
      if (cmd.take) begin
         note_ff <= note_on;
         rel_ff  <= start_release;
      end
      if (cmd.out_load) begin
         dac_ff <= sample_ff;
         stg_ff <= stage_ff;
         lvl_ff <= level_ff;
      end
   end

   assign status.div_busy = div_busy;
   assign status.out_free = !valid_ff || rsp_tready;

   assign rsp_tvalid = valid_ff;
   assign dac_value  = dac_ff;
   assign env_stage  = stg_ff;
   assign env_level  = lvl_ff;

endmodule

### src/avsq_ctrl.sv
// sequencing state machine for one tick item at a time
`timescale 1ns / 1ps

module avsq_ctrl
   import avsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_STEP;
         S_STEP: state_in = S_DIV;
         S_DIV:  if (!status.div_busy) state_in = S_OUT;
         S_OUT:  if (status.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      cmd.take     = (state_ff == S_IDLE) && req_tvalid;
      cmd.step     = (state_ff == S_STEP);
      cmd.out_load = (state_ff == S_OUT) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sim/adsr_square_voice_tb.sv
// self-checking testbench for the envelope and square voice, driven tick by tick
`timescale 1ns / 1ps

module adsr_square_voice_tb;
   import avsq_pkg::*;

   // no register sits at index 7, a write there must change nothing
   localparam logic [2:0] REG_UNUSED = 3'd7;

   // cycles with no item moving on either side before the run is given up
   localparam int QUIET_LIMIT   = 4000;
   // long receiver hold-off, started once in the phase with no idling
   localparam int HOLDOFF_CYCLES = 400;
   localparam int HOLDOFF_AFTER  = 50;
   // settle time after the last result
   localparam int SETTLE_CYCLES  = 25;

   // opening ticks, {start_release, note_on}: idle ticks, a held note, release with
   // and without the note on both tick parities, a fresh attack, then a last release
   localparam logic [0:23][1:0] OPENING = {
      2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
      2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd0
   };

   typedef struct {
      logic [15:0]   dac;
      env_stage_type stage;
      logic [15:0]   level;
   } voice_result_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;   // [0] note_on, [1] start_release, rest zero
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;            // [15:0] dac_value, [17:16] env_stage,
                                      // [33:18] env_level, rest zero
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = 5'd0;
   logic [31:0] csr_pwdata  = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // ticks waiting to be offered, and results the voice still owes us
   logic [1:0]       ticks_to_send [$];
   voice_result_type due_results [$];

   // idle chance per cycle, in percent, set by the phase sequencer only
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int bad_fields     = 0;
   int quiet_cycles   = 0;
   int calm_results   = 0;
   int holdoff_left   = 0;
   bit holdoff_done   = 1'b0;

   // shadow of the register file
   csr_type voice_cfg;

   // predicted voice state
   logic          skip_tick;
   env_stage_type env_stage;
   logic [7:0]    sub_count;
   logic [15:0]   time_count;
   logic [15:0]   env_level;
   logic [15:0]   step_interval;
   logic [15:0]   period_count;
   logic [7:0]    frac_acc;
   logic          square_phase;
   logic [15:0]   sample_out;

   adsr_square_voice uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ticks per envelope step, a zero divisor saturates
   function automatic logic [15:0] ticks_per_step(input logic [15:0] divisor);
      if (divisor == 16'd0)
         return FULL16;
      return TICK_UNIT / divisor;
   endfunction

   // shared decay/release shape: wait out the step interval, then drop one level;
   // returns 1 once the time limit is spent or the level hit zero
   function automatic bit ramp_level_down(input logic [7:0] limit);
      bit in_time;
      in_time = (time_count / TICK_UNIT) < {8'd0, limit};
      if ({8'd0, sub_count} < step_interval && in_time) begin
         sub_count  = sub_count + 8'd1;
         time_count = time_count + 16'd1;
         return 1'b0;
      end
      if (in_time && env_level != 16'd0) begin
         sub_count  = 8'd0;
         time_count = time_count + 16'd1;
         env_level  = env_level - 16'd1;
         return 1'b0;
      end
      sub_count  = 8'd0;
      time_count = 16'd0;
      return 1'b1;
   endfunction

   function automatic void advance_envelope();
      bit in_time;
      case (env_stage)
         STG_ATTACK: begin
            in_time = (time_count / TICK_UNIT) < {8'd0, voice_cfg.attack_time};
            if (sub_count < 8'd1 && in_time) begin
               sub_count  = sub_count + 8'd1;
               time_count = time_count + 16'd1;
            end else if (env_level < voice_cfg.peak_level && in_time) begin
               sub_count  = 8'd0;
               time_count = time_count + 16'd1;
               env_level  = env_level + 16'd1;
            end else begin
               sub_count     = 8'd0;
               time_count    = 16'd0;
               env_level     = voice_cfg.peak_level;
               step_interval = ticks_per_step(voice_cfg.sustain_level);
               env_stage     = STG_DECAY;
            end
         end
         STG_DECAY: begin
            if (ramp_level_down(voice_cfg.decay_time)) begin
               env_level = voice_cfg.sustain_level;
               // sustain above peak wraps the divisor modulo 2^16
               step_interval = ticks_per_step(voice_cfg.peak_level - voice_cfg.sustain_level);
               env_stage     = STG_SUSTAIN;
            end
         end
         STG_SUSTAIN: sub_count = sub_count + 8'd1;
         default: begin
            if (ramp_level_down(voice_cfg.release_time)) begin
               env_level     = 16'd0;
               step_interval = 16'd0;
               env_stage     = STG_ATTACK;
            end
         end
      endcase
   endfunction

   // one timer tick: returns the result item the voice must produce for it
   function automatic voice_result_type tick_voice(input logic note_on,
                                                   input logic start_release);
      voice_result_type res;
      // forced release applies on skipped ticks too
      if (start_release)
         env_stage = STG_RELEASE;
      if (!skip_tick) begin
         if (note_on || env_stage == STG_RELEASE) begin
            advance_envelope();
            if (period_count != 16'd0) begin
               period_count = period_count - 16'd1;
            end else begin
               // a zero period wraps to 65535 on reload
               if (frac_acc < FRAC_WRAP) begin
                  period_count = voice_cfg.period_ticks - 16'd1;
               end else begin
                  frac_acc     = frac_acc - FRAC_WRAP;
                  period_count = voice_cfg.period_ticks;
               end
               frac_acc = frac_acc + {1'b0, voice_cfg.period_hundredths};
            end
            if (period_count == 16'd1)
               square_phase = ~square_phase;
            sample_out = square_phase ? env_level : FULL16 - env_level;
            if (sample_out == 16'd0)
               sample_out = 16'd1;
         end else begin
            period_count = 16'd0;
            frac_acc     = 8'd0;
            sample_out   = 16'd1;
         end
      end
      skip_tick = ~skip_tick;
      res.dac   = sample_out;
      res.stage = env_stage;
      res.level = env_level;
      return res;
   endfunction

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      // register takes the value at the access edge
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_ATTACK_TIME:   voice_cfg.attack_time       = value[7:0];
         REG_DECAY_TIME:    voice_cfg.decay_time        = value[7:0];
         REG_RELEASE_TIME:  voice_cfg.release_time      = value[7:0];
         REG_SUSTAIN_LEVEL: voice_cfg.sustain_level     = value[15:0];
         REG_PEAK_LEVEL:    voice_cfg.peak_level        = value[15:0];
         REG_PERIOD_TICKS:  voice_cfg.period_ticks      = value[15:0];
         REG_PERIOD_HUND:   voice_cfg.period_hundredths = value[6:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_voice(input int attack, input int decay, input int rel,
                            input int sustain, input int peak, input int period,
                            input int hundredths);
      csr_write(REG_ATTACK_TIME,   attack);
      csr_write(REG_DECAY_TIME,    decay);
      csr_write(REG_RELEASE_TIME,  rel);
      csr_write(REG_SUSTAIN_LEVEL, sustain);
      csr_write(REG_PEAK_LEVEL,    peak);
      csr_write(REG_PERIOD_TICKS,  period);
      csr_write(REG_PERIOD_HUND,   hundredths);
   endtask

   // mostly whole notes: a held run, usually a release pulse, then a quiet tail;
   // the rest is random tick noise
   task automatic queue_notes(input int count);
      int made;
      int held;
      int tail;
      int k;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 9) < 8) begin
            held = $urandom_range(1, 60);
            tail = $urandom_range(0, 30);
            for (k = 0; k < held; k++)
               ticks_to_send.push_back(2'b01);
            if ($urandom_range(0, 3) != 0)
               ticks_to_send.push_back({1'b1, 1'($urandom_range(0, 1))});
            else
               ticks_to_send.push_back(2'b00);
            for (k = 0; k < tail; k++)
               ticks_to_send.push_back(2'b00);
            made += held + tail + 1;
         end else begin
            held = $urandom_range(1, 10);
            for (k = 0; k < held; k++)
               ticks_to_send.push_back(2'($urandom_range(0, 3)));
            made += held;
         end
      end
   endtask

   // every offered tick accepted and every result back: the voice is idle;
   // sampled on the falling edge so the clocked processes have settled
   task automatic wait_for_drain();
      while (ticks_to_send.size() != 0 || req_tvalid || due_results.size() != 0)
         @(negedge clock);
   endtask

   // phase sequencer
   initial begin
      int i;
      voice_cfg     = '{attack_time: 8'd1, decay_time: 8'd1, release_time: 8'd1,
                        sustain_level: 16'h2000, peak_level: 16'h3FFF,
                        period_ticks: 16'd1, period_hundredths: 7'd0};
      skip_tick     = 1'b1;
      env_stage     = STG_ATTACK;
      sub_count     = 8'd0;
      time_count    = 16'd0;
      env_level     = 16'd0;
      step_interval = 16'd0;
      period_count  = 16'd0;
      frac_acc      = 8'd0;
      square_phase  = 1'b1;
      sample_out    = 16'd1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles often, receiver more often
      send_idle_pct = 34;
      recv_idle_pct = 74;
      // short notes so every stage is reached quickly, release is instant
      set_voice(1, 1, 0, 26075, 4, 3, 50);
      for (i = 0; i < 24; i++)
         ticks_to_send.push_back(OPENING[i]);
      queue_notes(220);
      wait_for_drain();

      // zero sustain divides by zero, zero period wraps, full peak, no attack
      set_voice(0, 255, 1, 0, 65535, 0, 99);
      queue_notes(130);
      wait_for_drain();

      // roles swap: receiver idles less than the sender
      send_idle_pct = 74;
      recv_idle_pct = 34;
      // sustain above peak, widest period, fraction past its range, stray register
      set_voice(255, 0, 0, 65535, 2, 65535, 127);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      queue_notes(170);
      wait_for_drain();

      set_voice(1, 1, 0, 10430, 12, 2, 33);
      queue_notes(170);
      wait_for_drain();

      // no idling; the monitor adds its long hold-off in here
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_voice(2, 1, 0, 52150, 8, 5, 0);
      queue_notes(100);
      // sender pauses until the voice has returned everything
      wait_for_drain();
      queue_notes(100);
      wait_for_drain();

      set_voice($urandom_range(0, 3), $urandom_range(0, 2), $urandom_range(0, 1),
                $urandom_range(1, 65535), $urandom_range(0, 40), $urandom_range(0, 9),
                $urandom_range(0, 99));
      queue_notes(170);
      wait_for_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bad_fields == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // tick driver: predicts each item as it is taken, then offers the next one
   always @(posedge clock) begin : drive_ticks
      logic [1:0] next_tick;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            due_results.push_back(tick_voice(req_tdata[0], req_tdata[1]));
         if (!req_tvalid || req_tready) begin
            if (ticks_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_tick = ticks_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'd0, next_tick};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compares every taken item with the oldest prediction
   always @(posedge clock) begin : check_results
      voice_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               $error("result item with nothing expected: dac_value %0d", rsp_tdata[15:0]);
               bad_fields++;
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[15:0] !== want.dac) begin
                  $error("dac_value expected %0d got %0d", want.dac, rsp_tdata[15:0]);
                  bad_fields++;
               end
               if (rsp_tdata[17:16] !== want.stage) begin
                  $error("env_stage expected %0d got %0d", want.stage, rsp_tdata[17:16]);
                  bad_fields++;
               end
               if (rsp_tdata[33:18] !== want.level) begin
                  $error("env_level expected %0d got %0d", want.level, rsp_tdata[33:18]);
                  bad_fields++;
               end
            end
            // one long hold-off once idling is off, so the input side backs up
            if (send_idle_pct == 0 && recv_idle_pct == 0 && !holdoff_done) begin
               calm_results++;
               if (calm_results == HOLDOFF_AFTER) begin
                  holdoff_left = HOLDOFF_CYCLES;
                  holdoff_done = 1'b1;
               end
            end
         end
         if (holdoff_left != 0)
            holdoff_left--;
         rsp_tready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles in which no item moves either way
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
